@@ rtl/core/pbqg_pkg.sv @@
package pbqg_pkg;

	localparam int NumAxes    = 3;
	localparam int NumChans   = 4;
	localparam int CfgIdxW    = 3;
	localparam int CfgDataW   = 48;
	localparam int CoordW     = 32;
	localparam int TrigW      = 16;
	localparam int LifeW      = 16;
	localparam int SizeW      = 16;
	localparam int ChanW      = 8;

	// Q1.14 x Q1.14 product, sum of two, times Q8.8 size
	localparam int ProdW      = 2 * TrigW;
	localparam int RotW       = ProdW + 1;
	localparam int EdgeW      = RotW + SizeW + 1;
	// corner accumulator in Q.36 with headroom
	localparam int FracShift  = 20;
	localparam int AccW       = CoordW + FracShift + 2;

	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam cfg_idx_t RegCamRight  = 3'd0;
	localparam cfg_idx_t RegCamUp     = 3'd1;
	localparam cfg_idx_t RegSizeStart = 3'd2;
	localparam cfg_idx_t RegSizeEnd   = 3'd3;
	localparam cfg_idx_t RegColStart  = 3'd4;
	localparam cfg_idx_t RegColEnd    = 3'd5;

	localparam logic [47:0] CamRightRst  = 48'h0000_0000_4000;
	localparam logic [47:0] CamUpRst     = 48'h0000_4000_0000;
	localparam logic [15:0] SizeStartRst = 16'd256;
	localparam logic [15:0] SizeEndRst   = 16'd256;
	localparam logic [31:0] ColStartRst  = 32'hFFFF_FFFF;
	localparam logic [31:0] ColEndRst    = 32'h0000_0000;

	typedef logic [1:0] corner_t;

	localparam corner_t CornerLast = 2'd3;

	// +x edge on corners 1 and 2, +y edge on corners 2 and 3
	function automatic logic corner_pos_x(input corner_t k);
		return (k == 2'd1) || (k == 2'd2);
	endfunction

	function automatic logic corner_pos_y(input corner_t k);
		return k[1];
	endfunction

endpackage

@@ rtl/core/particle_billboard_quad_generator.sv @@
// Channel    | Handshake                      | Payload
// -----------+--------------------------------+------------------------------------------
// particle   | start in, busy out             | pos_x/y/z, life_frac, orient_cos/sin
// config     | cfg_valid in, cfg_ready out    | cfg_index, cfg_data
// vertex     | result_valid out (one cycle)   | vert_x/y/z, tex_u/v, color_*, corner_*
//
// A particle is taken when start is high and busy low; busy then stays high while the gap
// counter counts down, so particles are spaced apart, as set by the single vertex port.
// Three arithmetic stages (products, sums and lerp, size scaling) feed a corner stage
// that puts out one vertex a cycle, each vertex through a registered output to the receiver.
// Reset clears the valid bits and loads the register defaults. The receiver cannot
// stall, so nothing is ever held back; config writes are always ready.
module particle_billboard_quad_generator
	import pbqg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     start,
	output logic                     busy,
	input  logic signed [CoordW-1:0] pos_x,
	input  logic signed [CoordW-1:0] pos_y,
	input  logic signed [CoordW-1:0] pos_z,
	input  logic        [LifeW-1:0]  life_frac,
	input  logic signed [TrigW-1:0]  orient_cos,
	input  logic signed [TrigW-1:0]  orient_sin,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  cfg_idx_t                 cfg_index,
	input  logic [CfgDataW-1:0]      cfg_data,

	output logic                     result_valid,
	output logic signed [CoordW-1:0] vert_x,
	output logic signed [CoordW-1:0] vert_y,
	output logic signed [CoordW-1:0] vert_z,
	output logic                     tex_u,
	output logic                     tex_v,
	output logic        [ChanW-1:0]  color_r,
	output logic        [ChanW-1:0]  color_g,
	output logic        [ChanW-1:0]  color_b,
	output logic        [ChanW-1:0]  color_a,
	output corner_t                  corner_index,
	output logic                     last_corner
);

	localparam int SzProdW  = 2 * (SizeW + 1);
	localparam int ColProdW = (ChanW + 1) + (LifeW + 1);

	logic [47:0] cam_right_q, cam_up_q;
	logic [15:0] size_start_q, size_end_q;
	logic [31:0] col_start_q, col_end_q;
	logic [1:0]  gap_q;
	logic        accept;

	assign cfg_ready = 1'b1;
	assign busy      = (gap_q != 2'd0);
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_right_q  <= CamRightRst;
			cam_up_q     <= CamUpRst;
			size_start_q <= SizeStartRst;
			size_end_q   <= SizeEndRst;
			col_start_q  <= ColStartRst;
			col_end_q    <= ColEndRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegCamRight:  cam_right_q  <= cfg_data;
				RegCamUp:     cam_up_q     <= cfg_data;
				RegSizeStart: size_start_q <= cfg_data[15:0];
				RegSizeEnd:   size_end_q   <= cfg_data[15:0];
				RegColStart:  col_start_q  <= cfg_data[31:0];
				RegColEnd:    col_end_q    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// space accepts with the busy countdown so the corner stage is free on arrival
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 2'd0;
		end else if (accept) begin
			gap_q <= 2'd3;
		end else if (gap_q != 2'd0) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	// ---------------- stage 1: products ----------------
	logic signed [TrigW-1:0]    cam_r [NumAxes];
	logic signed [TrigW-1:0]    cam_u [NumAxes];
	logic signed [CoordW-1:0]   pos_in [NumAxes];
	logic signed [SizeW:0]      size_diff;
	logic signed [ChanW:0]      col_diff [NumChans];
	logic signed [LifeW:0]      life_s;

	always_comb begin
		for (int i = 0; i < NumAxes; i++) begin
			cam_r[i] = cam_right_q[16*i +: 16];
			cam_u[i] = cam_up_q[16*i +: 16];
		end
		pos_in[0] = pos_x;
		pos_in[1] = pos_y;
		pos_in[2] = pos_z;
		life_s    = signed'({1'b0, life_frac});
		size_diff = signed'({1'b0, size_start_q}) - signed'({1'b0, size_end_q});
		for (int j = 0; j < NumChans; j++) begin
			col_diff[j] = signed'({1'b0, col_start_q[8*j +: 8]})
				- signed'({1'b0, col_end_q[8*j +: 8]});
		end
	end

	logic                       v_s1;
	logic signed [ProdW-1:0]    cr_s1 [NumAxes];
	logic signed [ProdW-1:0]    su_s1 [NumAxes];
	logic signed [ProdW-1:0]    cu_s1 [NumAxes];
	logic signed [ProdW-1:0]    sr_s1 [NumAxes];
	logic signed [SzProdW-1:0]  szp_s1;
	logic signed [ColProdW-1:0] colp_s1 [NumChans];
	logic signed [CoordW-1:0]   pos_s1 [NumAxes];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < NumAxes; i++) begin
				cr_s1[i]  <= orient_cos * cam_r[i];
				su_s1[i]  <= orient_sin * cam_u[i];
				cu_s1[i]  <= orient_cos * cam_u[i];
				sr_s1[i]  <= orient_sin * cam_r[i];
				pos_s1[i] <= pos_in[i];
			end
			szp_s1 <= size_diff * life_s;
			for (int j = 0; j < NumChans; j++) begin
				colp_s1[j] <= col_diff[j] * life_s;
			end
		end
	end

	// ---------------- stage 2: rotate, lerp ----------------
	logic signed [SzProdW-LifeW:0] size_sum;
	logic signed [ColProdW-LifeW:0] col_sum [NumChans];

	always_comb begin
		size_sum = signed'({3'b000, size_end_q})
			+ (SzProdW-LifeW+1)'(szp_s1 >>> LifeW);
		for (int j = 0; j < NumChans; j++) begin
			col_sum[j] = signed'({3'b000, col_end_q[8*j +: 8]})
				+ (ColProdW-LifeW+1)'(colp_s1[j] >>> LifeW);
		end
	end

	logic                     v_s2;
	logic signed [RotW-1:0]   rp_s2 [NumAxes];
	logic signed [RotW-1:0]   rq_s2 [NumAxes];
	logic        [SizeW-1:0]  size_s2;
	logic        [ChanW-1:0]  col_s2 [NumChans];
	logic signed [CoordW-1:0] pos_s2 [NumAxes];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int i = 0; i < NumAxes; i++) begin
				rp_s2[i]  <= RotW'(cr_s1[i]) + RotW'(su_s1[i]);
				rq_s2[i]  <= RotW'(cu_s1[i]) - RotW'(sr_s1[i]);
				pos_s2[i] <= pos_s1[i];
			end
			// the lerp stays between its end points, so the low bits hold it
			size_s2 <= size_sum[SizeW-1:0];
			for (int j = 0; j < NumChans; j++) begin
				col_s2[j] <= col_sum[j][ChanW-1:0];
			end
		end
	end

	// ---------------- stage 3: scale by size ----------------
	logic signed [SizeW:0] size_sg;

	assign size_sg = signed'({1'b0, size_s2});

	logic                     v_s3;
	logic signed [EdgeW-1:0]  p_s3 [NumAxes];
	logic signed [EdgeW-1:0]  q_s3 [NumAxes];
	logic        [ChanW-1:0]  col_s3 [NumChans];
	logic signed [CoordW-1:0] pos_s3 [NumAxes];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			for (int i = 0; i < NumAxes; i++) begin
				p_s3[i]   <= rp_s2[i] * size_sg;
				q_s3[i]   <= rq_s2[i] * size_sg;
				pos_s3[i] <= pos_s2[i];
			end
			for (int j = 0; j < NumChans; j++) begin
				col_s3[j] <= col_s2[j];
			end
		end
	end

	// ---------------- corner stage ----------------
	logic                     act_q;
	corner_t                  k_q;
	logic signed [EdgeW-1:0]  p_q [NumAxes];
	logic signed [EdgeW-1:0]  q_q [NumAxes];
	logic        [ChanW-1:0]  col_q [NumChans];
	logic signed [CoordW-1:0] pos_q [NumAxes];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			k_q   <= '0;
		end else if (v_s3) begin
			act_q <= 1'b1;
			k_q   <= '0;
		end else if (act_q) begin
			k_q <= k_q + 2'd1;
			if (k_q == CornerLast) begin
				act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			for (int i = 0; i < NumAxes; i++) begin
				p_q[i]   <= p_s3[i];
				q_q[i]   <= q_s3[i];
				pos_q[i] <= pos_s3[i];
			end
			for (int j = 0; j < NumChans; j++) begin
				col_q[j] <= col_s3[j];
			end
		end
	end

	logic signed [AccW-1:0]   acc [NumAxes];
	logic signed [CoordW-1:0] crd [NumAxes];

	always_comb begin
		for (int i = 0; i < NumAxes; i++) begin
			// centre in Q.36 with the rounding half already in the empty low bits
			acc[i] = signed'({{(AccW-CoordW-FracShift){pos_q[i][CoordW-1]}}, pos_q[i],
				1'b1, {(FracShift-1){1'b0}}});
			acc[i] = corner_pos_x(k_q) ? acc[i] + AccW'(p_q[i]) : acc[i] - AccW'(p_q[i]);
			acc[i] = corner_pos_y(k_q) ? acc[i] + AccW'(q_q[i]) : acc[i] - AccW'(q_q[i]);
			// saturate when the bits above the result and its top bit do not all match the sign
			if (acc[i][AccW-1:AccW-3] != {3{acc[i][AccW-1]}}) begin
				crd[i] = acc[i][AccW-1] ? {1'b1, {(CoordW-1){1'b0}}}
					: {1'b0, {(CoordW-1){1'b1}}};
			end else begin
				crd[i] = acc[i][FracShift +: CoordW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= act_q;
		end
	end

	always_ff @(posedge clk) begin
		if (act_q) begin
			vert_x       <= crd[0];
			vert_y       <= crd[1];
			vert_z       <= crd[2];
			tex_u        <= corner_pos_x(k_q);
			tex_v        <= corner_pos_y(k_q);
			color_r      <= col_q[0];
			color_g      <= col_q[1];
			color_b      <= col_q[2];
			color_a      <= col_q[3];
			corner_index <= k_q;
			last_corner  <= (k_q == CornerLast);
		end
	end

endmodule

@@ tb/sv/pbqg_checker.sv @@
module pbqg_checker
	import pbqg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     start,
	input  logic                     busy,
	input  logic signed [CoordW-1:0] pos_x,
	input  logic signed [CoordW-1:0] pos_y,
	input  logic signed [CoordW-1:0] pos_z,
	input  logic        [LifeW-1:0]  life_frac,
	input  logic signed [TrigW-1:0]  orient_cos,
	input  logic signed [TrigW-1:0]  orient_sin,

	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  cfg_idx_t                 cfg_index,
	input  logic [CfgDataW-1:0]      cfg_data,

	input  logic                     result_valid,
	input  logic signed [CoordW-1:0] vert_x,
	input  logic signed [CoordW-1:0] vert_y,
	input  logic signed [CoordW-1:0] vert_z,
	input  logic                     tex_u,
	input  logic                     tex_v,
	input  logic        [ChanW-1:0]  color_r,
	input  logic        [ChanW-1:0]  color_g,
	input  logic        [ChanW-1:0]  color_b,
	input  logic        [ChanW-1:0]  color_a,
	input  corner_t                  corner_index,
	input  logic                     last_corner,

	output int                       fail_count,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [CoordW-1:0] z;
		logic              tex_u;
		logic              tex_v;
		logic [ChanW-1:0]  r;
		logic [ChanW-1:0]  g;
		logic [ChanW-1:0]  b;
		logic [ChanW-1:0]  a;
		corner_t           corner;
		logic              last;
	} vertex_t;

	vertex_t quad_q[$];
	vertex_t head;

	logic [CfgDataW-1:0]       cam_right;
	logic [CfgDataW-1:0]       cam_up;
	logic [SizeW-1:0]          size_full;
	logic [SizeW-1:0]          size_zero;
	logic [NumChans*ChanW-1:0] col_full;
	logic [NumChans*ChanW-1:0] col_zero;

	function automatic longint life_lerp(longint at_zero, longint at_full, longint life);
		return at_zero + (((at_full - at_zero) * life) >>> 16);
	endfunction

	// Q.36 down to Q16.16, nearest with ties upward, then clamp
	function automatic logic [CoordW-1:0] round_sat(longint acc);
		longint q;
		q = (acc + (longint'(1) <<< (FracShift - 1))) >>> FracShift;
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return q[CoordW-1:0];
	endfunction

	task automatic expand_quad();
		longint life, c, s, size, r, u, acc;
		longint pos[NumAxes];
		longint along_p[NumAxes];
		longint along_q[NumAxes];
		logic [CoordW-1:0] coord[NumAxes];
		logic [ChanW-1:0] col[NumChans];
		logic plus_x, plus_y;
		vertex_t v;
		int i, k;

		life = longint'(life_frac);
		c = longint'(orient_cos);
		s = longint'(orient_sin);
		pos[0] = longint'(pos_x);
		pos[1] = longint'(pos_y);
		pos[2] = longint'(pos_z);
		size = life_lerp(longint'(size_zero), longint'(size_full), life);

		for (i = 0; i < NumAxes; i++) begin
			r = longint'($signed(cam_right[TrigW*i +: TrigW]));
			u = longint'($signed(cam_up[TrigW*i +: TrigW]));
			along_p[i] = (c * r + s * u) * size;
			along_q[i] = (c * u - s * r) * size;
		end

		for (i = 0; i < NumChans; i++)
			col[i] = ChanW'(life_lerp(longint'(col_zero[ChanW*i +: ChanW]),
				longint'(col_full[ChanW*i +: ChanW]), life));

		for (k = 0; k < 4; k++) begin
			plus_x = (k == 1) || (k == 2);
			plus_y = (k >= 2);
			for (i = 0; i < NumAxes; i++) begin
				acc = pos[i] <<< FracShift;
				acc += plus_x ? along_p[i] : -along_p[i];
				acc += plus_y ? along_q[i] : -along_q[i];
				coord[i] = round_sat(acc);
			end
			v.x = coord[0];
			v.y = coord[1];
			v.z = coord[2];
			v.tex_u = plus_x;
			v.tex_v = plus_y;
			v.r = col[0];
			v.g = col[1];
			v.b = col[2];
			v.a = col[3];
			v.corner = corner_t'(k);
			v.last = (corner_t'(k) == CornerLast);
			quad_q.insert(quad_q.size(), v);
		end
	endtask

	task automatic check_field(input string label, input logic [CoordW-1:0] want,
		input logic [CoordW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_right  = CamRightRst;
			cam_up     = CamUpRst;
			size_full  = SizeStartRst;
			size_zero  = SizeEndRst;
			col_full   = ColStartRst;
			col_zero   = ColEndRst;
			quad_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (result_valid) begin
				if (quad_q.size() == 0) begin
					$display("%0t: vertex beat with none expected, expected none, actual corner %0d",
						$time, corner_index);
					fail_count++;
				end else begin
					head = quad_q.pop_front();
					check_field("vert_x", head.x, vert_x);
					check_field("vert_y", head.y, vert_y);
					check_field("vert_z", head.z, vert_z);
					check_field("tex_u", head.tex_u, tex_u);
					check_field("tex_v", head.tex_v, tex_v);
					check_field("color_r", head.r, color_r);
					check_field("color_g", head.g, color_g);
					check_field("color_b", head.b, color_b);
					check_field("color_a", head.a, color_a);
					check_field("corner_index", head.corner, corner_index);
					check_field("last_corner", head.last, last_corner);
				end
			end
			// predict with the settings in force before this edge
			if (start && !busy)
				expand_quad();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					RegCamRight:  cam_right = cfg_data;
					RegCamUp:     cam_up    = cfg_data;
					RegSizeStart: size_full = cfg_data[SizeW-1:0];
					RegSizeEnd:   size_zero = cfg_data[SizeW-1:0];
					RegColStart:  col_full  = cfg_data[NumChans*ChanW-1:0];
					RegColEnd:    col_zero  = cfg_data[NumChans*ChanW-1:0];
					default: ;
				endcase
			end
			pending = quad_q.size();
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pbqg_pkg::*;

	localparam int StallLimit = 2000;
	localparam int RandPhases = 8;
	localparam int PhaseItems = 32;
	localparam int TailCycles = 10;

	typedef enum int {CfgAllOnes, CfgAllZero, CfgRandom, CfgUnitCam} cfg_mode_e;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;

	logic                     start = 1'b0;
	logic                     busy;
	logic signed [CoordW-1:0] pos_x = '0;
	logic signed [CoordW-1:0] pos_y = '0;
	logic signed [CoordW-1:0] pos_z = '0;
	logic        [LifeW-1:0]  life_frac = '0;
	logic signed [TrigW-1:0]  orient_cos = '0;
	logic signed [TrigW-1:0]  orient_sin = '0;

	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	cfg_idx_t                 cfg_index = RegCamRight;
	logic [CfgDataW-1:0]      cfg_data = '0;

	logic                     result_valid;
	logic signed [CoordW-1:0] vert_x;
	logic signed [CoordW-1:0] vert_y;
	logic signed [CoordW-1:0] vert_z;
	logic                     tex_u;
	logic                     tex_v;
	logic        [ChanW-1:0]  color_r;
	logic        [ChanW-1:0]  color_g;
	logic        [ChanW-1:0]  color_b;
	logic        [ChanW-1:0]  color_a;
	corner_t                  corner_index;
	logic                     last_corner;

	int fail_count;
	int pending;
	int idle_run;
	bit gaps_on = 1'b1;

	particle_billboard_quad_generator uut (.*);

	pbqg_checker chk (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [TrigW-1:0] unit_half();
		logic [TrigW-1:0] h;
		h = TrigW'($urandom_range(0, 32768));
		return h - 16'd16384;
	endfunction

	task automatic send_particle(input logic [CoordW-1:0] px, input logic [CoordW-1:0] py,
		input logic [CoordW-1:0] pz, input logic [LifeW-1:0] life,
		input logic [TrigW-1:0] c, input logic [TrigW-1:0] s);
		int n;
		n = gaps_on ? gap_len() : 0;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
		pos_x      <= px;
		pos_y      <= py;
		pos_z      <= pz;
		life_frac  <= life;
		orient_cos <= c;
		orient_sin <= s;
		start      <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic send_rand_particle();
		logic [CoordW-1:0] p[NumAxes];
		logic [TrigW-1:0] c, s;
		int i;
		for (i = 0; i < NumAxes; i++) begin
			if ($urandom_range(0, 9) < 7)
				p[i] = $urandom;
			else
				p[i] = CoordW'($urandom_range(0, 2**21)) - CoordW'(2**20);
		end
		// mostly cos and sin each within -1.0 to +1.0, some raw patterns
		if ($urandom_range(0, 99) < 85) begin
			c = unit_half();
			s = unit_half();
		end else begin
			c = TrigW'($urandom);
			s = TrigW'($urandom);
		end
		send_particle(p[0], p[1], p[2], LifeW'($urandom), c, s);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_regs(input logic [CfgDataW-1:0] cr, input logic [CfgDataW-1:0] cu,
		input logic [CfgDataW-1:0] ss, input logic [CfgDataW-1:0] se,
		input logic [CfgDataW-1:0] cs, input logic [CfgDataW-1:0] ce);
		write_reg(RegCamRight, cr);
		write_reg(RegCamUp, cu);
		write_reg(RegSizeStart, ss);
		write_reg(RegSizeEnd, se);
		write_reg(RegColStart, cs);
		write_reg(RegColEnd, ce);
		// unused indexes must leave everything alone
		if ($urandom_range(0, 1))
			write_reg(cfg_idx_t'(RegColEnd + 1 + $urandom_range(0, 1)),
				CfgDataW'({$urandom, $urandom}));
		cfg_valid <= 1'b0;
	endtask

	task automatic load_setting(input cfg_mode_e mode);
		logic [CfgDataW-1:0] d[6];
		int i;
		for (i = 0; i < 6; i++)
			d[i] = CfgDataW'({$urandom, $urandom});
		case (mode)
			CfgAllOnes: begin
				for (i = 0; i < 6; i++)
					d[i] = '1;
			end
			CfgAllZero: begin
				for (i = 0; i < 6; i++)
					d[i] = '0;
			end
			CfgUnitCam: begin
				d[0] = {unit_half(), unit_half(), unit_half()};
				d[1] = {unit_half(), unit_half(), unit_half()};
				d[2][SizeW-1:0] = SizeW'($urandom_range(0, 2048));
				d[3][SizeW-1:0] = SizeW'($urandom_range(0, 2048));
			end
			default: ;
		endcase
		set_regs(d[0], d[1], d[2], d[3], d[4], d[5]);
	endtask

	// drop start and hold until every vertex has come out
	task automatic wait_idle();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		idle_run = 0;
		while (idle_run < StallLimit) begin
			@(posedge clk);
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("FAIL particle_billboard_quad_generator");
		$finish;
	end

	initial begin
		cfg_mode_e mode;
		int ph;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// settings straight out of reset
		send_particle(32'h0, 32'h0, 32'h0, 16'h0000, 16'h4000, 16'h0000);
		send_particle(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'hFFFF, 16'h4000, 16'h0000);
		send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'h4000, 16'h0000);
		send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF, 16'h4000, 16'h0000);
		send_particle(32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_8000, 16'h0001, 16'h0000, 16'h4000);
		send_particle(32'h0, 32'h0, 32'h0, 16'h8000, 16'hC000, 16'h0000);
		send_particle(32'h0, 32'h0, 32'h0, 16'h4000, 16'h0000, 16'hC000);
		send_particle(32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000);
		send_particle(32'h0, 32'h0, 32'h0, 16'h8000, 16'h7FFF, 16'h7FFF);
		send_particle(32'h0, 32'h0, 32'h0, 16'h8000, 16'h2D41, 16'h2D41);
		send_particle(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 16'hAAAA, 16'h5555, 16'hAAAA);

		// tiny size puts half-unit ties on both sides of zero
		wait_idle();
		set_regs(CamRightRst, CamUpRst, 48'd1, 48'd1, CfgDataW'(ColStartRst),
			CfgDataW'(ColEndRst));
		send_particle(32'h0, 32'h0, 32'h0, 16'h0000, 16'h0020, 16'h0000);
		send_particle(32'h0000_0001, 32'h0, 32'h0, 16'hFFFF, 16'hFFE0, 16'h0020);

		wait_idle();
		load_setting(CfgAllOnes);
		send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'h8000, 16'h8000);
		send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000, 16'h7FFF, 16'h7FFF);
		send_particle(32'h0, 32'h0, 32'h0, 16'h8000, 16'h4000, 16'hC000);

		wait_idle();
		load_setting(CfgAllZero);
		send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 16'hFFFF, 16'h4000, 16'h4000);

		// widest edge vectors and a falling colour ramp
		wait_idle();
		set_regs(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'hFFFF, 48'h0,
			48'h0, 48'hFFFF_FFFF);
		send_particle(32'h7FF0_0000, 32'h8010_0000, 32'h0, 16'hFFFF, 16'h8000, 16'h8000);
		send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h0000, 16'h8000, 16'h7FFF);
		send_particle(32'h0, 32'h0, 32'h0, 16'h8000, 16'h7FFF, 16'h8000);

		for (ph = 0; ph < RandPhases; ph++) begin
			wait_idle();
			if (ph < 2)
				mode = cfg_mode_e'(ph);
			else if ($urandom_range(0, 2) != 0)
				mode = CfgUnitCam;
			else
				mode = CfgRandom;
			load_setting(mode);
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat (PhaseItems)
				send_rand_particle();
		end

		wait_idle();
		repeat (TailCycles) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS particle_billboard_quad_generator");
		else
			$display("FAIL particle_billboard_quad_generator");
		$finish;
	end

endmodule

@@ particle_billboard_quad_generator.f @@
rtl/core/pbqg_pkg.sv
rtl/core/particle_billboard_quad_generator.sv
tb/sv/pbqg_checker.sv
tb/sv/tb_top.sv
